[rtl/plrt_pkg.sv]
`default_nettype none

package plrt_pkg;

	// command codes of an input request
	localparam logic [1:0] CMD_ESTABLISH = 2'd0;
	localparam logic [1:0] CMD_INDICATE  = 2'd1;
	localparam logic [1:0] CMD_TICK      = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_SEND    = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;
	localparam logic [1:0] KIND_FULL    = 2'd3;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MASK    = 1'b1;

	localparam logic [15:0] TIMEOUT_RESET    = 16'd10;
	localparam logic [7:0]  MASK_RESET       = 8'hC7;
	localparam logic [7:0]  TRAFFIC_LINK_BIT = 8'h40;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] chan_id;
		logic [7:0] link_value;
		logic       chan_is_traffic;
		logic       chan_signalling_mode;
		logic [7:0] indication_type;
	} in_item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] out_chan_id;
		logic [7:0] out_link_id;
		logic [7:0] out_indication;
		logic       last;
	} out_item_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  chan;
		logic [7:0]  link;
		logic [7:0]  mask;
		logic [15:0] timeout;
		logic        age_inc;
	} cell_ctl_t;

	// token walking down the row of cells
	typedef struct packed {
		logic       valid;
		logic       hit;
		logic [7:0] chan;
		logic [7:0] link;
	} probe_t;

	// a slot retiring on a tick
	typedef struct packed {
		logic       valid;
		logic [7:0] chan;
		logic [7:0] link;
	} slot_evt_t;

endpackage

`default_nettype wire

[rtl/plrt_cell.sv]
`default_nettype none

module plrt_cell #(
	parameter int AW = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  plrt_pkg::cell_ctl_t ctl,
	input  logic                rel_valid,
	input  logic [AW-1:0]       rel_age,
	input  plrt_pkg::probe_t    probe_in,
	input  logic [AW-1:0]       probe_age_in,
	output plrt_pkg::probe_t    probe_out,
	output logic [AW-1:0]       probe_age_out,
	output plrt_pkg::slot_evt_t expiry,
	output logic [AW-1:0]       expiry_age,
	output logic                occupied
);
	import plrt_pkg::*;

	logic          valid_q;
	logic [AW-1:0] age_q;
	logic [7:0]    chan_q;
	logic [7:0]    link_q;
	logic [15:0]   rem_q;
	logic          probe_vld_q;
	logic          probe_hit_q;
	logic [7:0]    probe_chan_q;
	logic [7:0]    probe_link_q;
	logic [AW-1:0] probe_age_q;

	logic act, link_hit, newer;
	logic claim, take, expire, count_dn, rel_self, rel_older;

	assign act      = advance && probe_in.valid;
	assign link_hit = ((link_q ^ ctl.link) & ctl.mask) == 8'h00;
	assign newer    = !probe_in.hit || (age_q < probe_age_in);

	assign claim  = act && (ctl.cmd == CMD_ESTABLISH) && !probe_in.hit && !valid_q;
	assign take   = act && (ctl.cmd == CMD_INDICATE) && valid_q &&
		(chan_q == ctl.chan) && link_hit && newer;
	assign expire   = act && (ctl.cmd == CMD_TICK) && valid_q && (rem_q <= 16'd1);
	assign count_dn = act && (ctl.cmd == CMD_TICK) && valid_q && !expire;

	// age compaction when some slot is freed
	assign rel_self  = rel_valid && valid_q && (age_q == rel_age);
	assign rel_older = rel_valid && valid_q && (age_q > rel_age);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else begin
			if (claim) begin
				valid_q <= 1'b1;
				age_q   <= '0;
			end else if (expire || rel_self) begin
				valid_q <= 1'b0;
				age_q   <= '0;
			end else if (valid_q && ctl.age_inc) begin
				age_q <= age_q + AW'(1);
			end else if (rel_older) begin
				age_q <= age_q - AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			chan_q <= ctl.chan;
			link_q <= ctl.link;
			rem_q  <= ctl.timeout;
		end else if (count_dn) begin
			rem_q <= rem_q - 16'd1;
		end
	end

	// probe stage toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_vld_q <= 1'b0;
		end else if (advance) begin
			probe_vld_q <= probe_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			probe_hit_q <= probe_in.hit || claim || take;
			if (take) begin
				probe_chan_q <= chan_q;
				probe_link_q <= link_q;
				probe_age_q  <= age_q;
			end else begin
				probe_chan_q <= probe_in.chan;
				probe_link_q <= probe_in.link;
				probe_age_q  <= probe_age_in;
			end
		end
	end

	assign probe_out.valid = probe_vld_q;
	assign probe_out.hit   = probe_hit_q;
	assign probe_out.chan  = probe_chan_q;
	assign probe_out.link  = probe_link_q;
	assign probe_age_out   = probe_age_q;

	assign expiry.valid = expire;
	assign expiry.chan  = chan_q;
	assign expiry.link  = link_q;
	assign expiry_age   = age_q;
	assign occupied     = valid_q;

endmodule

`default_nettype wire

[rtl/pending_link_request_table.sv]
// Pending link request table: DEPTH slots, each a cell in a row, track outstanding
// link-establish requests. An establish request takes the lowest free slot and
// returns a send result (or one table-full result); an indication completes the
// newest slot whose channel and masked link id match (no result if none); a tick
// counts every pending slot down and returns one timed-out result per expiring
// slot in slot order, last set on the final one. Command code 3 is dropped.
// One request is worked at a time: a token walks the row one cell per cycle, and
// a new request is accepted only once the previous one is back in idle; a
// table-full establish skips the walk and an unused code never leaves idle.
// The walk pauses whenever the output register holds a result that is stalled.
// Configuration must be written only while idle; the block does not enforce it.
`default_nettype none

module pending_link_request_table #(
	parameter int DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  plrt_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output plrt_pkg::out_item_t                 out_data,
	input  logic                                cfg_we,
	input  logic [plrt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [plrt_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import plrt_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// control
	logic [1:0]    state_q;
	logic          inj_q;
	logic          age_inc_q;
	logic [CW-1:0] count_q;
	logic          pend_valid_q;
	logic          out_valid_q;
	logic [15:0]   timeout_q;
	logic [7:0]    mask_q;

	// captured request and walk results
	logic [1:0]    op_q;
	logic [7:0]    chan_q;
	logic [7:0]    link_q;
	logic [7:0]    ind_q;
	logic          full_q;
	probe_t        end_q;
	logic [AW-1:0] end_age_q;
	slot_evt_t     pend_q;
	out_item_t     out_q;

	logic          acc;
	logic          advance;
	logic          fin;
	logic [7:0]    est_link;
	cell_ctl_t     ctl;
	probe_t        head_probe;
	logic [AW-1:0] head_age;
	probe_t        chain_probe [DEPTH];
	logic [AW-1:0] chain_age [DEPTH];
	slot_evt_t     expiry [DEPTH];
	logic [AW-1:0] expiry_age [DEPTH];
	logic [DEPTH-1:0] exp_vec;
	logic [DEPTH-1:0] occupied;
	slot_evt_t     ev;
	logic [AW-1:0] ev_age;
	logic          ind_rel;
	logic          rel_valid;
	logic [AW-1:0] rel_age;
	logic          claim_done;
	logic          load;
	out_item_t     load_item;
	probe_t        walk_end;

	// handshakes: the walk moves only while the output register can take a result
	assign in_stall  = (state_q != ST_IDLE);
	assign acc       = in_valid && (state_q == ST_IDLE);
	assign advance   = !out_valid_q || !out_stall;
	assign fin       = (state_q == ST_DONE) && advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// traffic channels outside signalling mode use the associated control link
	assign est_link = in_data.link_value |
		((in_data.chan_is_traffic && !in_data.chan_signalling_mode) ?
		TRAFFIC_LINK_BIT : 8'h00);

	always_comb begin
		ctl.cmd     = op_q;
		ctl.chan    = chan_q;
		ctl.link    = link_q;
		ctl.mask    = mask_q;
		ctl.timeout = timeout_q;
		ctl.age_inc = age_inc_q;
	end

	assign head_probe = '{valid: inj_q, hit: 1'b0, chan: 8'h00, link: 8'h00};
	assign head_age   = '0;

	// row of slot cells; the token leaves cell DEPTH-1 back to the controller
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		if (k == 0) begin : g_head
			plrt_cell #(.AW(AW)) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.advance      (advance),
				.ctl          (ctl),
				.rel_valid    (rel_valid),
				.rel_age      (rel_age),
				.probe_in     (head_probe),
				.probe_age_in (head_age),
				.probe_out    (chain_probe[k]),
				.probe_age_out(chain_age[k]),
				.expiry       (expiry[k]),
				.expiry_age   (expiry_age[k]),
				.occupied     (occupied[k])
			);
		end else begin : g_body
			plrt_cell #(.AW(AW)) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.advance      (advance),
				.ctl          (ctl),
				.rel_valid    (rel_valid),
				.rel_age      (rel_age),
				.probe_in     (chain_probe[k-1]),
				.probe_age_in (chain_age[k-1]),
				.probe_out    (chain_probe[k]),
				.probe_age_out(chain_age[k]),
				.expiry       (expiry[k]),
				.expiry_age   (expiry_age[k]),
				.occupied     (occupied[k])
			);
		end
		assign exp_vec[k] = expiry[k].valid;
	end

	assign walk_end = chain_probe[DEPTH-1];

	// only the cell holding the token can expire, so a plain merge will do
	always_comb begin
		ev     = '0;
		ev_age = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (expiry[k].valid) begin
				ev     = expiry[k];
				ev_age = expiry_age[k];
			end
		end
	end

	// freed slot: a tick expiry during the walk, or the matched slot of an indication
	assign ind_rel    = fin && (op_q == CMD_INDICATE) && end_q.hit;
	assign rel_valid  = ev.valid || ind_rel;
	assign rel_age    = ev.valid ? ev_age : end_age_q;
	assign claim_done = fin && (op_q == CMD_ESTABLISH) && !full_q;

	// result selection; timeouts are held back one so the final one gets last
	always_comb begin
		load      = 1'b0;
		load_item = '0;
		if (ev.valid && pend_valid_q) begin
			load                  = 1'b1;
			load_item.result_kind = KIND_TIMEOUT;
			load_item.out_chan_id = pend_q.chan;
			load_item.out_link_id = pend_q.link;
		end
		if (fin) begin
			case (op_q)
				CMD_ESTABLISH: begin
					load                  = 1'b1;
					load_item.result_kind = full_q ? KIND_FULL : KIND_SEND;
					load_item.out_chan_id = chan_q;
					load_item.out_link_id = link_q;
					load_item.last        = 1'b1;
				end
				CMD_INDICATE: begin
					if (end_q.hit) begin
						load                     = 1'b1;
						load_item.result_kind    = KIND_DONE;
						load_item.out_chan_id    = end_q.chan;
						load_item.out_link_id    = end_q.link;
						load_item.out_indication = ind_q;
						load_item.last           = 1'b1;
					end
				end
				CMD_TICK: begin
					if (pend_valid_q) begin
						load                  = 1'b1;
						load_item.result_kind = KIND_TIMEOUT;
						load_item.out_chan_id = pend_q.chan;
						load_item.out_link_id = pend_q.link;
						load_item.last        = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			inj_q        <= 1'b0;
			age_inc_q    <= 1'b0;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			timeout_q    <= TIMEOUT_RESET;
			mask_q       <= MASK_RESET;
		end else begin
			age_inc_q <= 1'b0;
			if (inj_q && advance)
				inj_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (in_data.cmd)
							CMD_ESTABLISH: begin
								if (count_q == CW'(DEPTH)) begin
									state_q <= ST_DONE;
								end else begin
									state_q   <= ST_WALK;
									inj_q     <= 1'b1;
									age_inc_q <= 1'b1;
								end
							end
							CMD_INDICATE, CMD_TICK: begin
								state_q <= ST_WALK;
								inj_q   <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					if (advance && walk_end.valid)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (advance)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (rel_valid)
				count_q <= count_q - CW'(1);
			else if (claim_done)
				count_q <= count_q + CW'(1);

			if (ev.valid)
				pend_valid_q <= 1'b1;
			else if (fin && (op_q == CMD_TICK))
				pend_valid_q <= 1'b0;

			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUT: timeout_q <= cfg_data;
					REG_MASK:    mask_q    <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q   <= in_data.cmd;
			chan_q <= in_data.chan_id;
			link_q <= (in_data.cmd == CMD_ESTABLISH) ? est_link : in_data.link_value;
			ind_q  <= in_data.indication_type;
			full_q <= (count_q == CW'(DEPTH));
		end
		if ((state_q == ST_WALK) && advance && walk_end.valid) begin
			end_q     <= walk_end;
			end_age_q <= chain_age[DEPTH-1];
		end
		if (ev.valid)
			pend_q <= ev;
		if (load)
			out_q <= load_item;
	end

	// occupancy counter agrees with the cells between requests
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ($countones(occupied) == int'(count_q)))
		else $error("slot count out of step with occupied cells");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("slot count beyond depth");

	a_one_expiry: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(exp_vec))
		else $error("more than one slot expired in a cycle");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> advance)
		else $error("result loaded over a stalled result");

	a_establish_claims: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WALK) && advance && walk_end.valid && (op_q == CMD_ESTABLISH))
		|-> walk_end.hit)
		else $error("establish walk found no free slot");

endmodule

`default_nettype wire

[tb/plrt_checker.sv]
`default_nettype none

module plrt_checker #(
	parameter int DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  plrt_pkg::in_item_t                  in_data,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  plrt_pkg::out_item_t                 out_data,
	input  logic                                cfg_we,
	input  logic [plrt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [plrt_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                  mismatches,
	output int                                  outstanding
);
	import plrt_pkg::*;

	// shadow of the table
	logic        slot_busy [DEPTH];
	logic [7:0]  slot_chan [DEPTH];
	logic [7:0]  slot_link [DEPTH];
	logic [15:0] slot_left [DEPTH];
	int          slot_rank [DEPTH];
	logic [15:0] timeout_q;
	logic [7:0]  mask_q;

	out_item_t   due_results [$];
	int          fail_n;

	function automatic out_item_t make_result(logic [1:0] kind, logic [7:0] chan,
			logic [7:0] link, logic [7:0] ind, logic last);
		out_item_t r;
		r.result_kind    = kind;
		r.out_chan_id    = chan;
		r.out_link_id    = link;
		r.out_indication = ind;
		r.last           = last;
		return r;
	endfunction

	// free a slot, older ranks move down so the ages stay packed
	task automatic retire_slot(int s);
		slot_busy[s] = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (slot_busy[i] && slot_rank[i] > slot_rank[s]) begin
				slot_rank[i]--;
			end
		end
		slot_rank[s] = 0;
	endtask

	task automatic apply_request(in_item_t req);
		logic [7:0] link;
		int         pick;
		int         n;
		out_item_t  tail;
		case (req.cmd)
			CMD_ESTABLISH: begin
				link = req.link_value;
				if (req.chan_is_traffic && !req.chan_signalling_mode) begin
					link = link | TRAFFIC_LINK_BIT;
				end
				pick = -1;
				for (int i = 0; i < DEPTH; i++) begin
					if (!slot_busy[i] && pick < 0) begin
						pick = i;
					end
				end
				if (pick < 0) begin
					due_results.push_back(make_result(KIND_FULL, req.chan_id, link, 8'h00, 1'b1));
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						if (slot_busy[i]) begin
							slot_rank[i]++;
						end
					end
					slot_busy[pick] = 1'b1;
					slot_chan[pick] = req.chan_id;
					slot_link[pick] = link;
					slot_left[pick] = timeout_q;
					slot_rank[pick] = 0;
					due_results.push_back(make_result(KIND_SEND, req.chan_id, link, 8'h00, 1'b1));
				end
			end
			CMD_INDICATE: begin
				pick = -1;
				for (int i = 0; i < DEPTH; i++) begin
					if (slot_busy[i] && slot_chan[i] == req.chan_id &&
							(slot_link[i] & mask_q) == (req.link_value & mask_q) &&
							(pick < 0 || slot_rank[i] < slot_rank[pick])) begin
						pick = i;
					end
				end
				if (pick >= 0) begin
					due_results.push_back(make_result(KIND_DONE, slot_chan[pick],
						slot_link[pick], req.indication_type, 1'b1));
					retire_slot(pick);
				end
			end
			CMD_TICK: begin
				n = 0;
				for (int i = 0; i < DEPTH; i++) begin
					if (slot_busy[i]) begin
						if (slot_left[i] <= 16'd1) begin
							slot_left[i] = 16'd0;
							due_results.push_back(make_result(KIND_TIMEOUT, slot_chan[i],
								slot_link[i], 8'h00, 1'b0));
							n++;
							retire_slot(i);
						end else begin
							slot_left[i]--;
						end
					end
				end
				if (n > 0) begin
					tail = due_results[$];
					void'(due_results.pop_back());
					tail.last = 1'b1;
					due_results.push_back(tail);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				slot_busy[i] = 1'b0;
				slot_rank[i] = 0;
			end
			timeout_q = TIMEOUT_RESET;
			mask_q    = MASK_RESET;
			due_results.delete();
			fail_n = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// results first: nothing accepted at this edge can answer at it
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					fail_n++;
					$display("%0t: unexpected result: expected none, got kind %0d chan %h link %h ind %h last %b",
						$time, out_data.result_kind, out_data.out_chan_id,
						out_data.out_link_id, out_data.out_indication, out_data.last);
				end else begin
					want = due_results.pop_front();
					if (out_data.result_kind !== want.result_kind ||
							out_data.out_chan_id !== want.out_chan_id ||
							out_data.out_link_id !== want.out_link_id ||
							out_data.out_indication !== want.out_indication ||
							out_data.last !== want.last) begin
						fail_n++;
						$display("%0t: result mismatch: expected kind %0d chan %h link %h ind %h last %b, got kind %0d chan %h link %h ind %h last %b",
							$time, want.result_kind, want.out_chan_id, want.out_link_id,
							want.out_indication, want.last, out_data.result_kind,
							out_data.out_chan_id, out_data.out_link_id,
							out_data.out_indication, out_data.last);
					end
				end
			end
			if (in_valid && !in_stall) begin
				apply_request(in_data);
			end
			if (cfg_we) begin
				if (cfg_index == REG_TIMEOUT) begin
					timeout_q = cfg_data[15:0];
				end else if (cfg_index == REG_MASK) begin
					mask_q = cfg_data[7:0];
				end
			end
			mismatches  <= fail_n;
			outstanding <= due_results.size();
		end
	end

endmodule

`default_nettype wire

[tb/pending_link_request_table_tb.sv]
`default_nettype none

module pending_link_request_table_tb;
	import plrt_pkg::*;

	localparam int DEPTH       = 8;
	localparam int SETTLE      = DEPTH + 6;   // a walk with no result may still be running
	localparam int HOLD_CYCLES = 400;         // long receiver hold-off, fills the block
	localparam int IDLE_LIMIT  = 4000;        // cycles with no handshake before giving up
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 62;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int outstanding;

	bit hold_off = 1'b0;   // raised by the request side, cleared by the sink after the hold
	bit calm     = 1'b0;   // request side sends back to back while set

	// recently established requests as {chan, link}, used to aim indications
	logic [15:0] issued [$];

	pending_link_request_table #(
		.DEPTH(DEPTH)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	plrt_checker #(
		.DEPTH(DEPTH)
	) table_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic in_item_t make_request(logic [1:0] cmd, logic [7:0] chan,
			logic [7:0] lv, logic traffic, logic sig, logic [7:0] ind);
		in_item_t r;
		r.cmd                  = cmd;
		r.chan_id              = chan;
		r.link_value           = lv;
		r.chan_is_traffic      = traffic;
		r.chan_signalling_mode = sig;
		r.indication_type      = ind;
		return r;
	endfunction

	// Offer one request and return at the edge that takes it. valid stays high
	// on return so a back-to-back request needs no second assignment.
	task automatic offer_request(in_item_t req);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering, wait for every predicted result, then let a silent walk finish.
	task automatic settle_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// result side: random stall pattern, plus one long hold-off on request
	initial begin : result_sink
		int open_len;
		int stall_len;
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				open_len = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 6);
				out_stall <= 1'b0;
				repeat (open_len) @(posedge clk);
				stall_len = pick_gap();
				if (stall_len > 0) begin
					out_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
				end
			end
		end
	end

	// watchdog: any handshake or register write counts as progress
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		logic [15:0] tmo_set  [PHASES];
		logic [7:0]  mask_set [PHASES];
		logic [15:0] ent;
		logic [7:0]  ch;
		logic [7:0]  lv;
		logic        traffic;
		logic        sig;
		int          r;
		int          k;

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part, reset settings (timeout 10, mask C7) ----
		// plain SAPI, then every bit of chan and link set on a traffic channel
		offer_request(make_request(CMD_ESTABLISH, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
		offer_request(make_request(CMD_ESTABLISH, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'hFF));
		// traffic, not signalling: the SACCH bit gets ORed in
		offer_request(make_request(CMD_ESTABLISH, 8'h12, 8'h3F, 1'b1, 1'b0, 8'h00));
		// traffic in signalling mode, then signalling flag on a non-traffic
		// channel: link id left alone; two identical pending requests
		offer_request(make_request(CMD_ESTABLISH, 8'h12, 8'h03, 1'b1, 1'b1, 8'h00));
		offer_request(make_request(CMD_ESTABLISH, 8'h12, 8'h03, 1'b0, 1'b1, 8'h00));
		// differs only in masked-out bits: completes the newer of the two
		offer_request(make_request(CMD_INDICATE, 8'h12, 8'h3B, 1'b0, 1'b0, 8'hFF));
		// no match: no result
		offer_request(make_request(CMD_INDICATE, 8'h12, 8'h04, 1'b1, 1'b1, 8'h5A));
		// unused command code is dropped
		offer_request(make_request(2'd3, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF));
		// fill the remaining slots, the last one finds the table full
		offer_request(make_request(CMD_ESTABLISH, 8'h21, 8'h80, 1'b0, 1'b0, 8'h00));
		offer_request(make_request(CMD_ESTABLISH, 8'h22, 8'h01, 1'b1, 1'b0, 8'h00));
		offer_request(make_request(CMD_ESTABLISH, 8'h23, 8'h02, 1'b0, 1'b1, 8'h00));
		offer_request(make_request(CMD_ESTABLISH, 8'h24, 8'h04, 1'b1, 1'b1, 8'h00));
		offer_request(make_request(CMD_ESTABLISH, 8'h25, 8'h08, 1'b1, 1'b0, 8'h00));
		offer_request(make_request(CMD_INDICATE, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00));
		// ten ticks: nothing until the last, then every pending slot times out
		repeat (10) begin
			offer_request(make_request(CMD_TICK, 8'($urandom), 8'($urandom), 1'b0, 1'b0,
				8'($urandom)));
		end
		settle_idle();

		// ---- random phases, one register setting each ----
		// zero timeout and both mask extremes are among them
		tmo_set  = '{16'd1, 16'd0, 16'hFFFF, 16'd3, 16'd2, 16'd0};
		mask_set = '{8'hFF, 8'h00, 8'hC7, 8'h38, 8'hF0, 8'h00};
		tmo_set[5]  = 16'($urandom_range(4, 20));
		mask_set[5] = 8'($urandom);

		for (int p = 0; p < PHASES; p++) begin
			// block is idle here: settle_idle ran just before
			cfg_we    <= 1'b1;
			cfg_index <= REG_TIMEOUT;
			cfg_data  <= tmo_set[p];
			@(posedge clk);
			cfg_index <= REG_MASK;
			cfg_data  <= {8'($urandom), mask_set[p]};
			@(posedge clk);
			cfg_we <= 1'b0;
			issued.delete();
			calm = ($urandom_range(3) == 0);

			k = 0;
			while (k < PHASE_ITEMS) begin
				// long hold-off while requests keep coming: block backs up
				if (p == 2 && k == 20 && !hold_off) begin
					hold_off = 1'b1;
				end
				// and a full drain mid-phase
				if (k == 40) begin
					settle_idle();
				end

				r  = $urandom_range(99);
				ch = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
				traffic = 1'($urandom);
				sig     = 1'($urandom);
				if (r < 42) begin
					lv = 8'($urandom);
					offer_request(make_request(CMD_ESTABLISH, ch, lv, traffic, sig, 8'($urandom)));
					if (traffic && !sig) begin
						lv = lv | TRAFFIC_LINK_BIT;
					end
					issued.push_back({ch, lv});
					if (issued.size() > 12) begin
						void'(issued.pop_front());
					end
					k++;
				end else if (r < 75) begin
					// mostly aimed at a pending request, noise in the ignored bits
					if (issued.size() > 0 && $urandom_range(4) != 0) begin
						ent = issued[$urandom_range(issued.size() - 1)];
						ch  = ent[15:8];
						lv  = ent[7:0] ^ (8'($urandom) & ~mask_set[p]);
					end else begin
						lv = 8'($urandom);
					end
					offer_request(make_request(CMD_INDICATE, ch, lv, traffic, sig, 8'($urandom)));
					k++;
				end else if (r < 96) begin
					offer_request(make_request(CMD_TICK, ch, 8'($urandom), traffic, sig,
						8'($urandom)));
					k++;
				end else begin
					offer_request(make_request(2'd3, ch, 8'($urandom), traffic, sig,
						8'($urandom)));
				end
			end
			settle_idle();
		end

		if (mismatches == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
